// ----- rtl/core/mble_pkg.sv -----
// ----------------------------------------------------------------------------
// mble_pkg: shared types and constants of the boundary loop extractor
// Holds the command codes, the field width, the result limit and the sequencer states.
// ----------------------------------------------------------------------------
package mble_pkg;

    localparam int VERT_W       = 7;
    localparam int RESULT_LIMIT = 64;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_ADD0,
        S_ADD1,
        S_ADD2,
        S_ADD3,
        S_SCAN_F,
        S_SCAN_B,
        S_SCAN_E,
        S_W_INIT,
        S_W_EMIT,
        S_W_TGT,
        S_W_SRCH,
        S_O_RD,
        S_O_OUT
    } state_t;

endpackage

// ----- rtl/core/mesh_boundary_loop_extract_top.sv -----
// ----------------------------------------------------------------------------
// mesh_boundary_loop_extract_top: boundary loop extraction for triangle meshes
// Counts directed edges of incoming faces in a count memory, then finds the
// boundary edges and walks them as one loop of vertex numbers.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                         Handshake
//  --------  ------------------------------  ------------------------------
//  command   cmd, v0, v1, v2                 taken when start && !busy
//  result    vertex, last, broken            one word per cycle on strobe
//  config    cfg_data (vertex_count)         written when cfg_valid && cfg_ready
//
// An add command makes three counter updates through the one write port and
// the one read port of the count memory, pipelined with forwarding.
// A finish command runs the pair scan (two reads per pair on the one read
// port), the walk over the boundary edges, the output of the result words
// and then a clearing pass over the count memory.
// The same clearing pass runs after reset; busy is high through all of it.
// The receiver cannot stall, so every result word is shown for one cycle.
//
module mesh_boundary_loop_extract_top #(
    parameter int MAX_VERTS   = 64,
    parameter int COUNT_WIDTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [mble_pkg::VERT_W-1:0] v0,
    input  logic [mble_pkg::VERT_W-1:0] v1,
    input  logic [mble_pkg::VERT_W-1:0] v2,
    output logic                        strobe,
    output logic [mble_pkg::VERT_W-1:0] vertex,
    output logic                        last,
    output logic                        broken,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mble_pkg::VERT_W-1:0] cfg_data
);
    import mble_pkg::*;

    // Index widths: VW holds a vertex index, CW a count up to MAX_VERTS.
    localparam int VW    = $clog2(MAX_VERTS);
    localparam int CW    = $clog2(MAX_VERTS + 1);
    localparam int DEPTH = MAX_VERTS * MAX_VERTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(RESULT_LIMIT);
    localparam int RCW   = $clog2(RESULT_LIMIT + 1);

    localparam logic [8:0]             MAXV9     = 9'(MAX_VERTS);
    localparam logic [CW-1:0]          MAXV_C    = CW'(MAX_VERTS);
    localparam logic [AW-1:0]          LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX      = {COUNT_WIDTH{1'b1}};
    localparam logic [8:0]             LIMIT9    = 9'(RESULT_LIMIT);

    function automatic logic vtx_ok(input logic [VERT_W-1:0] v);
        return (v != '0) && ({2'b00, v} <= MAXV9);
    endfunction

    function automatic logic [VW-1:0] idx_of(input logic [VERT_W-1:0] v);
        logic [8:0] t;
        t = {2'b00, v} - 9'd1;
        return t[VW-1:0];
    endfunction

    function automatic logic [VERT_W-1:0] vtx_of(input logic [VW-1:0] i);
        logic [8:0] t;
        t = 9'(i) + 9'd1;
        return t[VERT_W-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [VW-1:0] s,
                                              input logic [VW-1:0] d);
        return AW'(s * MAX_VERTS) + AW'(d);
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == CMAX) ? c : c + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Memories: edge counts, edge list and the result buffer.
    // ------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0] cnt_mem [DEPTH];
    logic [VW-1:0]          src_mem [MAX_VERTS];
    logic [VW-1:0]          tgt_mem [MAX_VERTS];
    logic [VERT_W-1:0]      res_mem [RESULT_LIMIT];

    logic                   cnt_we;
    logic [AW-1:0]          cnt_waddr, cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_q;
    logic                   edge_we;
    logic [VW-1:0]          edge_waddr, edge_raddr;
    logic [VW-1:0]          src_q, tgt_q;
    logic                   res_we;
    logic [RW-1:0]          res_waddr, res_raddr;
    logic [VERT_W-1:0]      res_wdata, res_q;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [VERT_W-1:0]      vcount_reg;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [VW-1:0]          a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [COUNT_WIDTH-1:0] w0_reg, w0_next, w1_reg, w1_next;
    logic [COUNT_WIDTH-1:0] fwd_reg, fwd_next;
    logic [CW-1:0]          n_reg, n_next, i_reg, i_next, j_reg, j_next;
    logic [CW-1:0]          total_reg, total_next;
    logic                   found_reg, found_next;
    logic                   broken_reg, broken_next;
    logic [VW-1:0]          best_reg, best_next, best_edge_reg, best_edge_next;
    logic [VW-1:0]          cur_reg, cur_next, start_reg, start_next;
    logic [VW-1:0]          cur_edge_reg, cur_edge_next;
    logic [VW-1:0]          want_reg, want_next, k_reg, k_next;
    logic [RCW-1:0]         count_reg, count_next, oidx_reg, oidx_next;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            src_mem[edge_waddr] <= i_reg[VW-1:0];
            tgt_mem[edge_waddr] <= j_reg[VW-1:0];
        end
        src_q <= src_mem[edge_raddr];
        tgt_q <= tgt_mem[edge_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_waddr] <= res_wdata;
        end
        res_q <= res_mem[res_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            vcount_reg    <= VERT_W'(64);
            clr_reg       <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            w0_reg        <= '0;
            w1_reg        <= '0;
            fwd_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            total_reg     <= '0;
            found_reg     <= 1'b0;
            broken_reg    <= 1'b0;
            best_reg      <= '0;
            best_edge_reg <= '0;
            cur_reg       <= '0;
            start_reg     <= '0;
            cur_edge_reg  <= '0;
            want_reg      <= '0;
            k_reg         <= '0;
            count_reg     <= '0;
            oidx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
            clr_reg       <= clr_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            w0_reg        <= w0_next;
            w1_reg        <= w1_next;
            fwd_reg       <= fwd_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            total_reg     <= total_next;
            found_reg     <= found_next;
            broken_reg    <= broken_next;
            best_reg      <= best_next;
            best_edge_reg <= best_edge_next;
            cur_reg       <= cur_next;
            start_reg     <= start_next;
            cur_edge_reg  <= cur_edge_next;
            want_reg      <= want_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            oidx_reg      <= oidx_next;
        end
    end

    // ------------------------------------------------------------------
    // Shared conditions.
    // ------------------------------------------------------------------
    logic          accept;
    logic          face_ok;
    logic [8:0]    n_eff;
    logic [AW-1:0] e0_addr, e1_addr, e2_addr;
    logic          is_bnd;
    logic          i_last, j_last;
    logic          src_hit;
    logic          steps_done;
    logic          k_end;
    logic          out_last;

    assign accept   = start && !busy;
    assign face_ok  = vtx_ok(v0) && vtx_ok(v1) && vtx_ok(v2);
    // A register value above MAX_VERTS acts as MAX_VERTS.
    assign n_eff    = ({2'b00, vcount_reg} > MAXV9) ? MAXV9 : {2'b00, vcount_reg};
    assign e0_addr  = addr_of(a_reg, b_reg);
    assign e1_addr  = addr_of(b_reg, c_reg);
    assign e2_addr  = addr_of(c_reg, a_reg);
    // In the evaluate cycle fwd_reg holds count(i->j) and cnt_q count(j->i).
    assign is_bnd   = ({1'b0, fwd_reg} == ({1'b0, cnt_q} + 1'b1));
    assign i_last   = (i_reg + 1'b1) == n_reg;
    assign j_last   = (j_reg + 1'b1) == n_reg;
    assign src_hit  = (src_q == want_reg);
    assign steps_done = (9'(count_reg) >= 9'(total_reg)) || (9'(count_reg) >= LIMIT9);
    assign k_end    = (9'(k_reg) + 9'd1) >= 9'(total_reg);
    assign out_last = (oidx_reg + 1'b1) == count_reg;

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_FINISH)
                    begin
                        state_next = (n_eff == 9'd0) ? S_W_INIT : S_SCAN_F;
                    end
                    else if (face_ok)
                    begin
                        state_next = S_ADD0;
                    end
                end
            end
            S_ADD0:   state_next = S_ADD1;
            S_ADD1:   state_next = S_ADD2;
            S_ADD2:   state_next = S_ADD3;
            S_ADD3:   state_next = S_IDLE;
            S_SCAN_F: state_next = S_SCAN_B;
            S_SCAN_B: state_next = S_SCAN_E;
            S_SCAN_E:
            begin
                state_next = (i_last && j_last) ? S_W_INIT : S_SCAN_F;
            end
            S_W_INIT:
            begin
                state_next = (total_reg == '0) ? S_O_RD : S_W_EMIT;
            end
            S_W_EMIT: state_next = S_W_TGT;
            S_W_TGT:  state_next = S_W_SRCH;
            S_W_SRCH:
            begin
                if (src_hit)
                begin
                    if ((src_q == start_reg) || steps_done)
                    begin
                        state_next = S_O_RD;
                    end
                    else
                    begin
                        state_next = S_W_EMIT;
                    end
                end
                else if (k_end)
                begin
                    state_next = S_O_RD;
                end
            end
            S_O_RD:   state_next = S_O_OUT;
            S_O_OUT:
            begin
                if (out_last)
                begin
                    state_next = S_CLR;
                end
            end
            default:  state_next = S_CLR;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control.
    // ------------------------------------------------------------------
    always_comb
    begin
        cnt_we         = 1'b0;
        cnt_waddr      = e0_addr;
        cnt_wdata      = '0;
        cnt_raddr      = e0_addr;
        edge_we        = 1'b0;
        edge_waddr     = total_reg[VW-1:0];
        edge_raddr     = cur_edge_reg;
        res_we         = 1'b0;
        res_waddr      = count_reg[RW-1:0];
        res_wdata      = vtx_of(cur_reg);
        res_raddr      = '0;

        clr_next       = clr_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        fwd_next       = fwd_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        total_next     = total_reg;
        found_next     = found_reg;
        broken_next    = broken_reg;
        best_next      = best_reg;
        best_edge_next = best_edge_reg;
        cur_next       = cur_reg;
        start_next     = start_reg;
        cur_edge_next  = cur_edge_reg;
        want_next      = want_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        oidx_next      = oidx_reg;

        unique case (state_reg)
            S_CLR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                clr_next = '0;
                if (accept)
                begin
                    a_next      = idx_of(v0);
                    b_next      = idx_of(v1);
                    c_next      = idx_of(v2);
                    n_next      = n_eff[CW-1:0];
                    i_next      = '0;
                    j_next      = '0;
                    total_next  = '0;
                    found_next  = 1'b0;
                    broken_next = 1'b0;
                    best_next   = '0;
                    best_edge_next = '0;
                end
            end
            S_ADD0:
            begin
                cnt_raddr = e0_addr;
            end
            S_ADD1:
            begin
                w0_next   = sat_inc(cnt_q);
                cnt_we    = 1'b1;
                cnt_waddr = e0_addr;
                cnt_wdata = sat_inc(cnt_q);
                cnt_raddr = e1_addr;
            end
            S_ADD2:
            begin
                // The read of edge b->c overlapped the write of edge a->b.
                cnt_wdata = sat_inc((e1_addr == e0_addr) ? w0_reg : cnt_q);
                w1_next   = cnt_wdata;
                cnt_we    = 1'b1;
                cnt_waddr = e1_addr;
                cnt_raddr = e2_addr;
            end
            S_ADD3:
            begin
                cnt_wdata = sat_inc((e2_addr == e1_addr) ? w1_reg : cnt_q);
                cnt_we    = 1'b1;
                cnt_waddr = e2_addr;
            end
            S_SCAN_F:
            begin
                cnt_raddr = addr_of(i_reg[VW-1:0], j_reg[VW-1:0]);
            end
            S_SCAN_B:
            begin
                fwd_next  = cnt_q;
                cnt_raddr = addr_of(j_reg[VW-1:0], i_reg[VW-1:0]);
            end
            S_SCAN_E:
            begin
                if (is_bnd)
                begin
                    if (total_reg == MAXV_C)
                    begin
                        broken_next = 1'b1;
                    end
                    else
                    begin
                        edge_we = 1'b1;
                        if (!found_reg || (i_reg[VW-1:0] < best_reg))
                        begin
                            best_next      = i_reg[VW-1:0];
                            best_edge_next = total_reg[VW-1:0];
                            found_next     = 1'b1;
                        end
                        total_next = total_reg + 1'b1;
                    end
                end
                if (i_last)
                begin
                    i_next = '0;
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_W_INIT:
            begin
                if (total_reg == '0)
                begin
                    // Empty boundary gives a single word with vertex zero.
                    res_we     = 1'b1;
                    res_waddr  = '0;
                    res_wdata  = '0;
                    count_next = RCW'(1);
                end
                else
                begin
                    cur_next      = best_reg;
                    start_next    = best_reg;
                    cur_edge_next = best_edge_reg;
                    count_next    = '0;
                end
            end
            S_W_EMIT:
            begin
                res_we     = 1'b1;
                res_waddr  = count_reg[RW-1:0];
                res_wdata  = vtx_of(cur_reg);
                count_next = count_reg + 1'b1;
                edge_raddr = cur_edge_reg;
            end
            S_W_TGT:
            begin
                want_next  = tgt_q;
                k_next     = '0;
                edge_raddr = '0;
            end
            S_W_SRCH:
            begin
                // The next entry is read ahead while this one is compared.
                edge_raddr = k_reg + 1'b1;
                if (src_hit)
                begin
                    cur_next      = src_q;
                    cur_edge_next = k_reg;
                end
                else if (k_end)
                begin
                    broken_next = 1'b1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_O_RD:
            begin
                res_raddr = '0;
                oidx_next = '0;
            end
            S_O_OUT:
            begin
                res_raddr = RW'(oidx_reg + 1'b1);
                oidx_next = oidx_reg + 1'b1;
                clr_next  = '0;
            end
            default:
            begin
                clr_next = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Ports.
    // ------------------------------------------------------------------
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign strobe    = (state_reg == S_O_OUT);
    assign vertex    = res_q;
    assign last      = out_last;
    assign broken    = broken_reg;

endmodule
